### src/eft_pkg.sv
// ----------------------------------------------------------------------------
// eft_pkg: shared types and codes for the event flag table
// Request codes, response status codes, clear modes and the table write
// control group.
// ----------------------------------------------------------------------------
package eft_pkg;

   localparam int FUNC_W   = 3;
   localparam int ID_W     = 4;
   localparam int WORD_W   = 64;
   localparam int CMODE_W  = 2;
   localparam int STATUS_W = 2;

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_CREATE  = 3'd0,
      FUNC_DESTROY = 3'd1,
      FUNC_SET     = 3'd2,
      FUNC_CLEAR   = 3'd3,
      FUNC_GET     = 3'd4,
      FUNC_WAIT    = 3'd5
   } func_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_BADID = 2'd2,
      STATUS_UNSAT = 2'd3
   } status_type;

   // clear modes after a satisfied wait
   localparam logic [CMODE_W-1:0] CMODE_KEEP    = 2'd0;
   localparam logic [CMODE_W-1:0] CMODE_PATTERN = 2'd1;
   localparam logic [CMODE_W-1:0] CMODE_WORD    = 2'd2;

   // table write controls, one request's worth
   typedef struct packed {
      logic word_we;    // write the flag word
      logic valid_set;  // mark slot allocated
      logic valid_clr;  // mark slot free
   } tbl_wr_type;

endpackage

### src/eft_free_find.sv
// ----------------------------------------------------------------------------
// eft_free_find: lowest free slot search
// Priority encoder over the slot valid bits, returning the lowest clear bit.
// ----------------------------------------------------------------------------
module eft_free_find #(
   parameter int NUM_FLAGS = 16,
   parameter int IDX_W     = 4
) (
   input  logic [NUM_FLAGS-1:0] slot_valid,
   output logic                 found,
   output logic [IDX_W-1:0]     free_idx
);

   // scan from the top so the lowest free slot wins
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int k = NUM_FLAGS - 1; k >= 0; k--) begin
         if (!slot_valid[k]) begin
            found    = 1'b1;
            free_idx = IDX_W'(k);
         end
      end
   end

endmodule

### src/eft_flag_table.sv
// ----------------------------------------------------------------------------
// eft_flag_table: flag word storage and slot valid bits
// One write port driven by the execute stage, one combinational read port.
// Valid bits clear on reset; flag words hold no reset value.
// ----------------------------------------------------------------------------
module eft_flag_table #(
   parameter int NUM_FLAGS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  eft_pkg::tbl_wr_type      wr_ctl,
   input  logic [IDX_W-1:0]         wr_idx,
   input  logic [eft_pkg::WORD_W-1:0] wr_word,
   input  logic [IDX_W-1:0]         rd_idx,
   output logic [eft_pkg::WORD_W-1:0] rd_word,
   output logic [NUM_FLAGS-1:0]     slot_valid
);

   import eft_pkg::*;

   logic [WORD_W-1:0]    words_ff [NUM_FLAGS];
   logic [NUM_FLAGS-1:0] valid_ff;

   // flag words, written by create, set, clear and clearing waits
   always_ff @(posedge clock) begin
      if (wr_ctl.word_we) begin
         words_ff[wr_idx] <= wr_word;
      end
   end

   // slot allocation bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ctl.valid_set) begin
         valid_ff[wr_idx] <= 1'b1;
      end else if (wr_ctl.valid_clr) begin
         valid_ff[wr_idx] <= 1'b0;
      end
   end

   assign rd_word    = words_ff[rd_idx];
   assign slot_valid = valid_ff;

endmodule

### src/event_flag_table.sv
// ----------------------------------------------------------------------------
// event_flag_table: table of 64-bit event flag words
// Create, destroy, set, clear, get and non-blocking wait on flag words kept
// in a small slot table, one request per beat, one response per request.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start / busy         | req_func req_flag_id req_pattern
//            |                      | req_wait_all req_clear_mode
//  response  | rsp_valid (strobe)   | rsp_status rsp_new_id rsp_flag_value
//
// A request beat is taken when start is high and busy is low; busy is high
// only during reset, so one request is taken every cycle.
// Each response passes through the request register, then the execute stage
// (table read, free-slot encode, update) and into the response register.
// The table write and the response register load at the same edge, so the
// next request always sees the updated table.
// Reset clears the valid bits and both stage flags; the receiver cannot stall.
// ----------------------------------------------------------------------------
module event_flag_table #(
   parameter int NUM_FLAGS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [eft_pkg::FUNC_W-1:0]  req_func,
   input  logic [eft_pkg::ID_W-1:0]    req_flag_id,
   input  logic [eft_pkg::WORD_W-1:0]  req_pattern,
   input  logic                        req_wait_all,
   input  logic [eft_pkg::CMODE_W-1:0] req_clear_mode,
   output logic                        rsp_valid,
   output logic [eft_pkg::STATUS_W-1:0] rsp_status,
   output logic [eft_pkg::ID_W-1:0]    rsp_new_id,
   output logic [eft_pkg::WORD_W-1:0]  rsp_flag_value
);

   import eft_pkg::*;

   localparam int IDX_W = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;

   // request register
   logic                 req_vld_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [ID_W-1:0]      id_ff;
   logic [WORD_W-1:0]    pattern_ff;
   logic                 wait_all_ff;
   logic [CMODE_W-1:0]   cmode_ff;

   // response register
   logic                 rsp_vld_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [ID_W-1:0]      new_id_ff;
   logic [WORD_W-1:0]    value_ff;

   // execute stage
   logic [STATUS_W-1:0]  status_in;
   logic [ID_W-1:0]      new_id_in;
   logic [WORD_W-1:0]    value_in;
   tbl_wr_type           wr_ctl;
   logic [IDX_W-1:0]     wr_idx;
   logic [WORD_W-1:0]    wr_word;
   logic [IDX_W-1:0]     slot_idx;
   logic                 id_ok;
   logic [WORD_W-1:0]    cur_word;
   logic [NUM_FLAGS-1:0] slot_valid;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;
   logic [WORD_W-1:0]    hit;
   logic                 wait_ok;
   logic                 accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // request beat capture
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff     <= req_func;
         id_ff       <= req_flag_id;
         pattern_ff  <= req_pattern;
         wait_all_ff <= req_wait_all;
         cmode_ff    <= req_clear_mode;
      end
   end

   // storage and free-slot search
   eft_flag_table #(
      .NUM_FLAGS (NUM_FLAGS),
      .IDX_W     (IDX_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_ctl     (wr_ctl),
      .wr_idx     (wr_idx),
      .wr_word    (wr_word),
      .rd_idx     (slot_idx),
      .rd_word    (cur_word),
      .slot_valid (slot_valid)
   );

   eft_free_find #(
      .NUM_FLAGS (NUM_FLAGS),
      .IDX_W     (IDX_W)
   ) u_free (
      .slot_valid (slot_valid),
      .found      (free_found),
      .free_idx   (free_idx)
   );

   // addressed slot check
   assign slot_idx = IDX_W'(id_ff);
   assign id_ok    = (32'(id_ff) < 32'(NUM_FLAGS)) && slot_valid[slot_idx];
   assign hit      = cur_word & pattern_ff;
   assign wait_ok  = wait_all_ff ? (hit == pattern_ff) : (hit != '0);

   // request decode and table update
   always_comb begin
      status_in = STATUS_OK;
      new_id_in = '0;
      value_in  = '0;
      wr_ctl    = '0;
      wr_idx    = slot_idx;
      wr_word   = cur_word;
      if (req_vld_ff) begin
         unique case (func_ff) inside
            FUNC_CREATE: begin
               if (free_found) begin
                  wr_ctl.word_we   = 1'b1;
                  wr_ctl.valid_set = 1'b1;
                  wr_idx           = free_idx;
                  wr_word          = pattern_ff;
                  new_id_in        = ID_W'(free_idx);
               end else begin
                  status_in = STATUS_FULL;
               end
            end
            FUNC_DESTROY, FUNC_SET, FUNC_CLEAR, FUNC_GET, FUNC_WAIT: begin
               if (!id_ok) begin
                  status_in = STATUS_BADID;
               end else begin
                  unique case (func_ff)
                     FUNC_DESTROY: wr_ctl.valid_clr = 1'b1;
                     FUNC_SET: begin
                        wr_ctl.word_we = 1'b1;
                        wr_word        = cur_word | pattern_ff;
                     end
                     FUNC_CLEAR: begin
                        wr_ctl.word_we = 1'b1;
                        wr_word        = hit;
                     end
                     FUNC_GET: value_in = cur_word;
                     default: begin
                        // non-blocking wait
                        if (wait_ok) begin
                           value_in = cur_word;
                           if (cmode_ff == CMODE_PATTERN) begin
                              wr_ctl.word_we = 1'b1;
                              wr_word        = cur_word & ~pattern_ff;
                           end else if (cmode_ff == CMODE_WORD) begin
                              wr_ctl.word_we = 1'b1;
                              wr_word        = '0;
                           end
                        end else begin
                           status_in = STATUS_UNSAT;
                        end
                     end
                  endcase
               end
            end
            default: ;  // unknown codes answer ok with no effect
         endcase
      end
   end

   // response beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         status_ff <= status_in;
         new_id_ff <= new_id_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_status     = status_ff;
   assign rsp_new_id     = new_id_ff;
   assign rsp_flag_value = value_ff;

   // a full response means every slot was taken when it was decided
   a_full_means_all_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> (&slot_valid))
      else $error("table full reported with a free slot");

   // a successful create leaves its slot allocated
   a_create_allocates: assert property (@(posedge clock) disable iff (reset)
      req_vld_ff && (func_ff == FUNC_CREATE) && free_found
      |=> slot_valid[$past(free_idx)])
      else $error("created slot not marked valid");

   // error responses carry no id and no word
   a_error_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_new_id == '0) && (rsp_flag_value == '0))
      else $error("error response with nonzero payload");

   // allocation state only moves when a request is executing
   a_idle_keeps_valid: assert property (@(posedge clock) disable iff (reset)
      !req_vld_ff |=> $stable(slot_valid))
      else $error("slot valid bits changed with no request");

endmodule
